[rtl/core/q8_24_fixed_point_alu_unit_assert.svh]
// Assertion helpers for the Q8.24 ALU; expect clk and rst_n in scope.
`ifndef Q8_24_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define Q8_24_FIXED_POINT_ALU_UNIT_ASSERT_SVH

// Same-cycle implication.
`define Q8FX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define Q8FX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/q8fx_pkg.sv]
package q8fx_pkg;

    localparam int FRAC_BITS_DEF = 24;

    localparam logic [3:0] FN_ADD      = 4'd0;
    localparam logic [3:0] FN_SUB      = 4'd1;
    localparam logic [3:0] FN_MUL      = 4'd2;
    localparam logic [3:0] FN_DIV      = 4'd3;
    localparam logic [3:0] FN_ABS      = 4'd4;
    localparam logic [3:0] FN_INT2FIX  = 4'd5;
    localparam logic [3:0] FN_FIX2BYTE = 4'd6;
    localparam logic [3:0] FN_ADC2S    = 4'd7;
    localparam logic [3:0] FN_ADC2P    = 4'd8;
    localparam logic [3:0] FN_FIX2ADC  = 4'd9;

    localparam logic [31:0] ADC_MID        = 32'd2048;
    localparam int          ADC_SHIFT_S    = 13;
    localparam int          ADC_SHIFT_P    = 12;
    localparam logic [31:0] ADC_MASK       = 32'h0000_0FFF;
    localparam logic [31:0] BYTE_MASK      = 32'h0000_00FF;
    localparam logic [31:0] FIX_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] FIX_MIN        = 32'h8000_0000;

    // Payload that rides alongside the divider stages.
    typedef struct packed {
        logic [3:0]         func;
        logic [31:0]        simple;
        logic signed [63:0] prod;
        logic               neg_q;
        logic               dz;
        logic [31:0]        dz_val;
    } side_t;

endpackage

[rtl/core/q8fx_div_stage.sv]
module q8fx_div_stage #(
    parameter int W = 56
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            valid_in,
    input  q8fx_pkg::side_t side_in,
    input  logic [31:0]     rem_in,
    input  logic [W-1:0]    quo_in,
    input  logic [31:0]     dvs_in,
    output logic            valid_out,
    output q8fx_pkg::side_t side_out,
    output logic [31:0]     rem_out,
    output logic [W-1:0]    quo_out,
    output logic [31:0]     dvs_out
);
    import q8fx_pkg::*;

    logic            valid_reg;
    side_t           side_reg;
    logic [31:0]     rem_reg;
    logic [W-1:0]    quo_reg;
    logic [31:0]     dvs_reg;
    logic [31:0]     rem_next;
    logic [W-1:0]    quo_next;

    // Two restoring steps; quotient bits shift in at the bottom of quo.
    always_comb
    begin
        logic [32:0] trial;
        logic [31:0] r;
        logic [W-1:0] q;
        r = rem_in;
        q = quo_in;
        for (int k = 0; k < 2; k++)
        begin
            trial = {r, q[W-1]};
            q = {q[W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_in})
            begin
                trial = trial - {1'b0, dvs_in};
                q[0] = 1'b1;
            end
            r = trial[31:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side_reg <= side_in;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_in;
        end
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign dvs_out   = dvs_reg;

endmodule

[rtl/core/q8_24_fixed_point_alu_unit.sv]
// Q8.24 fixed-point ALU: add, sub, mul, div, abs and integer/ADC conversions.
// Input channel: in_valid/in_stall with func, operand_a, operand_b. One
// transfer per cycle is taken while the output side keeps up.
// Output channel: out_valid/out_stall with result, one result per item, in
// input order.
// Every func passes the same pipeline, which is set by the radix-4 restoring divider:
// one register stage per two quotient bits over the 32 + FRAC_BITS bit shifted
// dividend. The multiplier sits in the first stage, its product shifted at the output.
// Throughput: one item per cycle while out_stall does not hold the pipeline.
// When out_stall is high with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline is empty and ready at once.
// Divide by zero returns max for a nonnegative dividend, min otherwise.
module q8_24_fixed_point_alu_unit #(
    parameter int FRAC_BITS = q8fx_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         func,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result
);
    import q8fx_pkg::*;

    localparam int DW    = 32 + FRAC_BITS;
    localparam int STEPS = (DW + 1) / 2;
    localparam int W     = 2 * STEPS;

    logic        advance;
    logic        v_pipe    [0:STEPS];
    side_t       side_pipe [0:STEPS];
    logic [31:0] rem_pipe  [0:STEPS];
    logic [W-1:0] quo_pipe [0:STEPS];
    logic [31:0] dvs_pipe  [0:STEPS];

    logic        v0_reg;
    side_t       side0_reg;
    logic [W-1:0] quo0_reg;
    logic [31:0] dvs0_reg;
    side_t       side0_next;
    logic [31:0] mag_a;
    logic [31:0] mag_b;

    logic        out_valid_reg;
    logic [31:0] result_reg;
    logic [31:0] result_next;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    assign mag_a = operand_a[31] ? (32'd0 - operand_a) : operand_a;
    assign mag_b = operand_b[31] ? (32'd0 - operand_b) : operand_b;

    always_comb
    begin
        logic [31:0] ua;
        logic [31:0] sh;
        ua = operand_a;
        side0_next.func   = func;
        side0_next.prod   = operand_a * operand_b;
        side0_next.neg_q  = operand_a[31] ^ operand_b[31];
        side0_next.dz     = (operand_b == 32'sd0);
        side0_next.dz_val = operand_a[31] ? FIX_MIN : FIX_MAX;
        sh = 32'(operand_a >>> FRAC_BITS);
        case (func)
            FN_ADD:      side0_next.simple = ua + operand_b;
            FN_SUB:      side0_next.simple = ua - operand_b;
            FN_ABS:      side0_next.simple = mag_a;
            FN_INT2FIX:  side0_next.simple = ua << FRAC_BITS;
            FN_FIX2BYTE: side0_next.simple = sh & BYTE_MASK;
            FN_ADC2S:    side0_next.simple = (ua - ADC_MID) << ADC_SHIFT_S;
            FN_ADC2P:    side0_next.simple = ua << ADC_SHIFT_P;
            FN_FIX2ADC:  side0_next.simple =
                             (32'(operand_a >>> ADC_SHIFT_S) + ADC_MID) & ADC_MASK;
            default:     side0_next.simple = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side0_reg <= side0_next;
            quo0_reg  <= W'({mag_a, {FRAC_BITS{1'b0}}});
            dvs0_reg  <= mag_b;
        end
    end

    assign v_pipe[0]    = v0_reg;
    assign side_pipe[0] = side0_reg;
    assign rem_pipe[0]  = 32'd0;
    assign quo_pipe[0]  = quo0_reg;
    assign dvs_pipe[0]  = dvs0_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_div
        q8fx_div_stage #(.W(W)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (v_pipe[i]),
            .side_in   (side_pipe[i]),
            .rem_in    (rem_pipe[i]),
            .quo_in    (quo_pipe[i]),
            .dvs_in    (dvs_pipe[i]),
            .valid_out (v_pipe[i+1]),
            .side_out  (side_pipe[i+1]),
            .rem_out   (rem_pipe[i+1]),
            .quo_out   (quo_pipe[i+1]),
            .dvs_out   (dvs_pipe[i+1])
        );
    end

    always_comb
    begin
        logic [31:0] qmag;
        qmag = quo_pipe[STEPS][31:0];
        case (side_pipe[STEPS].func)
            FN_MUL:  result_next = side_pipe[STEPS].prod[FRAC_BITS+31:FRAC_BITS];
            FN_DIV:
            begin
                if (side_pipe[STEPS].dz)
                    result_next = side_pipe[STEPS].dz_val;
                else if (side_pipe[STEPS].neg_q)
                    result_next = 32'd0 - qmag;
                else
                    result_next = qmag;
            end
            default: result_next = side_pipe[STEPS].simple;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= v_pipe[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

`include "q8_24_fixed_point_alu_unit_assert.svh"

    `Q8FX_ASSERT_NOW(a_stall_tracks_out, 1'b1, in_stall == (out_valid_reg && out_stall),
        "input stall does not follow output backpressure")
    `Q8FX_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v0_reg,
        "accepted transfer did not enter the first stage")
    `Q8FX_ASSERT_NEXT(a_hold_last, in_stall, $stable(v_pipe[STEPS]),
        "last divider stage moved while held")

endmodule

[tb/tb_q8_24_fixed_point_alu_unit.sv]
module tb_q8_24_fixed_point_alu_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import q8fx_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int NUM_RANDOM = 1430;
    localparam int IDLE_LIMIT = 5000;

    class alu_scoreboard;
        logic [31:0] pending[$];
        int mismatches;
        int extras;

        function logic [31:0] compute(logic [3:0] fn, logic [31:0] a, logic [31:0] b);
            logic signed [63:0] prod;
            logic signed [63:0] num;
            logic signed [63:0] quo;
            logic [31:0] r;
            r = '0;
            case (fn)
                FN_ADD: r = a + b;
                FN_SUB: r = a - b;
                FN_MUL:
                begin
                    prod = $signed(a) * $signed(b);
                    prod = prod >>> FRAC;
                    r = prod[31:0];
                end
                FN_DIV:
                begin
                    if (b == 0)
                        r = a[31] ? FIX_MIN : FIX_MAX;
                    else
                    begin
                        num = 64'($signed(a)) <<< FRAC;
                        quo = num / 64'($signed(b));
                        r = quo[31:0];
                    end
                end
                FN_ABS: r = a[31] ? (32'd0 - a) : a;
                FN_INT2FIX: r = a << FRAC;
                FN_FIX2BYTE: r = ($signed(a) >>> FRAC) & BYTE_MASK;
                FN_ADC2S: r = (a - ADC_MID) << ADC_SHIFT_S;
                FN_ADC2P: r = a << ADC_SHIFT_P;
                FN_FIX2ADC: r = (($signed(a) >>> ADC_SHIFT_S) + ADC_MID) & ADC_MASK;
                default: r = '0;
            endcase
            return r;
        endfunction

        function void note_operation(logic [3:0] fn, logic [31:0] a, logic [31:0] b);
            pending.push_back(compute(fn, a, b));
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (pending.size() == 0)
            begin
                extras++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h got %h", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [3:0] func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] result;

    alu_scoreboard sb;
    int idle_cycles;
    int busy_phase;    // 1: no idling on either side
    bit hold_off;      // long receiver stall

    q8_24_fixed_point_alu_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 4095);
            4: return {{8{1'b0}}, 24'($urandom)} | (32'($urandom_range(0, 15)) << FRAC);
            5: return -32'($urandom_range(0, 32'h0400_0000));
            6: return 32'($urandom_range(0, 32'h0400_0000));
            default: return $urandom;
        endcase
    endfunction

    // One transfer; valid stays high back to back and is dropped only for random idle gaps.
    task automatic send_op(logic [3:0] fn, logic [31:0] a, logic [31:0] b);
        while (busy_phase == 0 && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= fn;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_operation(fn, a, b);
        @(negedge clk);
    endtask

    // Receiver stall pattern
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (busy_phase != 0)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int i;
        logic [31:0] corner[6];
        logic [3:0] fn;
        sb = new();
        busy_phase = 0;
        hold_off = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        operand_a = '0;
        operand_b = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0100_0000, 32'hFF00_0000,
                   32'hFFFF_FFFF};
        // every func, including unused codes, with extreme operands
        for (i = 0; i < 16; i++)
            send_op(4'(i), corner[i % 6], corner[(i + 3) % 6]);
        send_op(FN_DIV, 32'h0123_4567, 32'h0);     // divide by zero, nonnegative
        send_op(FN_DIV, 32'h8000_0000, 32'h0);     // divide by zero, negative
        send_op(FN_DIV, 32'h7FFF_FFFF, 32'h0000_0001); // wide quotient wraps
        send_op(FN_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_op(FN_ABS, 32'h8000_0000, 32'h0);     // abs of minimum
        send_op(FN_ADC2S, 32'h0000_0FFF, 32'h0);
        send_op(FN_ADC2P, 32'hFFFF_FFFF, 32'h0);
        send_op(FN_FIX2ADC, 32'h8000_0000, 32'h0);

        for (i = 0; i < NUM_RANDOM; i++)
        begin
            if (i == 300)
                busy_phase = 1;
            if (i == 500)
                busy_phase = 0;
            if (i == 700)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            fn = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
            send_op(fn, rand_operand(), rand_operand());
        end
        in_valid <= 1'b0;

        i = 0;
        while (sb.pending.size() != 0 && i < 100000)
        begin
            @(posedge clk);
            i++;
        end
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
